/* rtl/bilinear_upsample_2d_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear upsampler
// Shared property shapes used by the checker of the block.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_UPSAMPLE_2D_ASSERT_SVH
`define BILINEAR_UPSAMPLE_2D_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BU2D_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("bilinear upsampler: same-cycle property failed");

// Next-cycle implication, ignored while reset is asserted.
`define BU2D_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("bilinear upsampler: next-cycle property failed");

// Next-cycle implication that is also checked across reset.
`define BU2D_ASSERT_ALW(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("bilinear upsampler: reset property failed");

`endif

/* rtl/bu2d_pkg.sv */
// ---------------------------------------------------------------------------
// bu2d_pkg
// Shared constants and register codes of the bilinear upsampler.
// ---------------------------------------------------------------------------
package bu2d_pkg;

    localparam int DEF_MAX_IN_SIZE  = 256;
    localparam int DEF_MAX_OUT_SIZE = 4096;
    localparam int DEF_SAMPLE_BITS  = 16;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_SIZE_W  = 9;
    localparam int CFG_SCALE_W = 24;
    localparam int FRAC_BITS   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_H       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_W       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_CORNERS = 3'd4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    // 1.0 in the 16-bit fraction format of scales, coordinates and weights.
    localparam logic [FRAC_BITS:0] ONE_Q16 = 17'h1_0000;

endpackage

/* rtl/bu2d_if.sv */
// ---------------------------------------------------------------------------
// bu2d_if
// Valid/ready channels of the bilinear upsampler: request and result.
// ---------------------------------------------------------------------------
interface bu2d_in_if
    import bu2d_pkg::*;
#(
    parameter int IDX_W       = $clog2(DEF_MAX_IN_SIZE),
    parameter int DST_W       = $clog2(DEF_MAX_OUT_SIZE),
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              col;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [DST_W-1:0]              out_y;
    logic [DST_W-1:0]              out_x;

    modport source (output valid, op, row, col, sample, out_y, out_x, input ready);
    modport sink   (input valid, op, row, col, sample, out_y, out_x, output ready);
endinterface

interface bu2d_out_if
    import bu2d_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

/* rtl/bilinear_upsample_2d.sv */
// ---------------------------------------------------------------------------
// bilinear_upsample_2d
// Fixed-point bilinear upsampler over one stored image plane.
// ---------------------------------------------------------------------------
// The block holds one image plane and answers interpolate transactions at a
// rate of one transaction per clock cycle unless a waiting result stalls it.
// A write transaction stores one sample and gives no result; an interpolate
// transaction gives one rounded, saturated pixel. The plane is split into two
// banks by row parity, each with two read ports, so the four neighbours of a
// pixel are fetched in one read of both banks, which sets the one-per-cycle
// rate. Reads and writes reach the banks from the same pipeline stage in
// arrival order, so a write is always visible to every later interpolate. The
// store has no reset and no clearing pass: software must ensure it writes
// every sample of the plane before it interpolates from it. Configuration
// must be written only while idle. The block itself enforces neither rule.
// ---------------------------------------------------------------------------
module bilinear_upsample_2d
    import bu2d_pkg::*;
#(
    parameter int MAX_IN_SIZE  = DEF_MAX_IN_SIZE,
    parameter int MAX_OUT_SIZE = DEF_MAX_OUT_SIZE,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bu2d_in_if.sink               i_in,
    bu2d_out_if.source            o_out
);
    // Index and coordinate widths.
    localparam int IDX_W     = $clog2(MAX_IN_SIZE);
    localparam int DST_W     = $clog2(MAX_OUT_SIZE);
    localparam int HALF_ROWS = (MAX_IN_SIZE + 1) / 2;
    localparam int HR_W      = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int AW        = HR_W + IDX_W;
    localparam int PROD_W    = CFG_SCALE_W + DST_W + 1;
    localparam int IP_W      = PROD_W - FRAC_BITS;
    localparam int MAP_W     = IDX_W + FRAC_BITS;
    localparam int W_W       = FRAC_BITS + 2;
    localparam int TOP_W     = SAMPLE_BITS + W_W;
    localparam int ACC_W     = TOP_W + W_W;
    localparam int V_W       = ACC_W - 32;

    // Configuration registers.
    logic [CFG_SIZE_W-1:0]  r_in_height;
    logic [CFG_SIZE_W-1:0]  r_in_width;
    logic [CFG_SCALE_W-1:0] r_scale_h;
    logic [CFG_SCALE_W-1:0] r_scale_w;
    logic                   r_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height <= CFG_SIZE_W'(1);
            r_in_width  <= CFG_SIZE_W'(1);
            r_scale_h   <= CFG_SCALE_W'(ONE_Q16);
            r_scale_w   <= CFG_SCALE_W'(ONE_Q16);
            r_align     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IN_HEIGHT:     r_in_height <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_IN_WIDTH:      r_in_width  <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_SCALE_H:       r_scale_h   <= i_cfg_data[CFG_SCALE_W-1:0];
                REG_SCALE_W:       r_scale_w   <= i_cfg_data[CFG_SCALE_W-1:0];
                REG_ALIGN_CORNERS: r_align     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Last valid row and column index. A size of zero acts as one and a size
    // beyond the store acts as the store size.
    logic [IDX_W-1:0] h_m1;
    logic [IDX_W-1:0] w_m1;

    always_comb begin
        if (r_in_height == '0) begin
            h_m1 = '0;
        end else if (32'(r_in_height) > MAX_IN_SIZE) begin
            h_m1 = IDX_W'(MAX_IN_SIZE - 1);
        end else begin
            h_m1 = IDX_W'(r_in_height - CFG_SIZE_W'(1));
        end
        if (r_in_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_in_width) > MAX_IN_SIZE) begin
            w_m1 = IDX_W'(MAX_IN_SIZE - 1);
        end else begin
            w_m1 = IDX_W'(r_in_width - CFG_SIZE_W'(1));
        end
    end

    // The whole pipeline advances together unless a result is waiting.
    logic adv;
    assign adv        = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    // Stage 1: capture the transaction, fold the store index, drop
    // interpolations outside the output range.
    logic                          r1_vld;
    logic                          r1_op;
    logic [IDX_W-1:0]              r1_row;
    logic [IDX_W-1:0]              r1_col;
    logic signed [SAMPLE_BITS-1:0] r1_smp;
    logic [DST_W-1:0]              r1_oy;
    logic [DST_W-1:0]              r1_ox;
    logic                          n1_vld;
    logic [IDX_W-1:0]              n1_row;
    logic [IDX_W-1:0]              n1_col;

    always_comb begin
        n1_row = ({1'b0, i_in.row} >= (IDX_W+1)'(MAX_IN_SIZE))
               ? IDX_W'({1'b0, i_in.row} - (IDX_W+1)'(MAX_IN_SIZE)) : i_in.row;
        n1_col = ({1'b0, i_in.col} >= (IDX_W+1)'(MAX_IN_SIZE))
               ? IDX_W'({1'b0, i_in.col} - (IDX_W+1)'(MAX_IN_SIZE)) : i_in.col;
        n1_vld = i_in.valid && ((i_in.op == OP_WRITE) ||
                 (({1'b0, i_in.out_y} < (DST_W+1)'(MAX_OUT_SIZE)) &&
                  ({1'b0, i_in.out_x} < (DST_W+1)'(MAX_OUT_SIZE))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= n1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_op  <= i_in.op;
            r1_row <= n1_row;
            r1_col <= n1_col;
            r1_smp <= i_in.sample;
            r1_oy  <= i_in.out_y;
            r1_ox  <= i_in.out_x;
        end
    end

    // Stage 2: scale times the destination coordinate. Without aligned
    // corners the coordinate is taken as 2*dst+1 in half-pixel units.
    logic                          r2_vld;
    logic                          r2_op;
    logic [IDX_W-1:0]              r2_row;
    logic [IDX_W-1:0]              r2_col;
    logic signed [SAMPLE_BITS-1:0] r2_smp;
    logic [PROD_W-1:0]             r2_ph;
    logic [PROD_W-1:0]             r2_pw;
    logic [DST_W:0]                m_y;
    logic [DST_W:0]                m_x;
    logic [PROD_W-1:0]             n2_ph;
    logic [PROD_W-1:0]             n2_pw;

    always_comb begin
        m_y   = r_align ? {1'b0, r1_oy} : {r1_oy, 1'b1};
        m_x   = r_align ? {1'b0, r1_ox} : {r1_ox, 1'b1};
        n2_ph = r_scale_h * m_y;
        n2_pw = r_scale_w * m_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_op  <= r1_op;
            r2_row <= r1_row;
            r2_col <= r1_col;
            r2_smp <= r1_smp;
            r2_ph  <= n2_ph;
            r2_pw  <= n2_pw;
        end
    end

    // Stage 3: source index and fraction per axis, plus the neighbour index.
    function automatic logic [MAP_W-1:0] map_axis(
        input logic [PROD_W-1:0] p,
        input logic              ac,
        input logic [IDX_W-1:0]  lim
    );
        logic [PROD_W-1:0] src;
        logic [IP_W-1:0]   ip;
        logic [MAP_W-1:0]  res;
        if (ac) begin
            src = p;
        end else if (p >= PROD_W'(ONE_Q16)) begin
            src = (p - PROD_W'(ONE_Q16)) >> 1;
        end else begin
            src = '0;
        end
        ip = src[PROD_W-1:FRAC_BITS];
        if (ip > IP_W'(lim)) begin
            res = {lim, {FRAC_BITS{1'b0}}};
        end else begin
            res = {ip[IDX_W-1:0], src[FRAC_BITS-1:0]};
        end
        return res;
    endfunction

    logic                          r3_vld;
    logic                          r3_op;
    logic [IDX_W-1:0]              r3_row;
    logic [IDX_W-1:0]              r3_col;
    logic signed [SAMPLE_BITS-1:0] r3_smp;
    logic [IDX_W-1:0]              r3_y0;
    logic [IDX_W-1:0]              r3_y1;
    logic [IDX_W-1:0]              r3_x0;
    logic [IDX_W-1:0]              r3_x1;
    logic [FRAC_BITS-1:0]          r3_fy;
    logic [FRAC_BITS-1:0]          r3_fx;
    logic                          r3_ey;
    logic [MAP_W-1:0]              map_y;
    logic [MAP_W-1:0]              map_x;
    logic [IDX_W-1:0]              n3_y0;
    logic [IDX_W-1:0]              n3_x0;

    always_comb begin
        map_y = map_axis(r2_ph, r_align, h_m1);
        map_x = map_axis(r2_pw, r_align, w_m1);
        n3_y0 = map_y[MAP_W-1:FRAC_BITS];
        n3_x0 = map_x[MAP_W-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_op  <= r2_op;
            r3_row <= r2_row;
            r3_col <= r2_col;
            r3_smp <= r2_smp;
            r3_y0  <= n3_y0;
            r3_x0  <= n3_x0;
            r3_y1  <= (n3_y0 < h_m1) ? n3_y0 + IDX_W'(1) : n3_y0;
            r3_x1  <= (n3_x0 < w_m1) ? n3_x0 + IDX_W'(1) : n3_x0;
            r3_ey  <= !(n3_y0 < h_m1);
            r3_fy  <= map_y[FRAC_BITS-1:0];
            r3_fx  <= map_x[FRAC_BITS-1:0];
        end
    end

    // Memory access. Even rows live in one bank and odd rows in the other,
    // so the upper and lower rows of a pixel come from different banks. At
    // the bottom edge both rows are the same row and the lower one is copied
    // from the upper one after the read.
    logic                   rd_en;
    logic                   wr_en;
    logic [IDX_W-1:0]       row_e;
    logic [IDX_W-1:0]       row_o;
    logic [AW-1:0]          ra_e0;
    logic [AW-1:0]          ra_e1;
    logic [AW-1:0]          ra_o0;
    logic [AW-1:0]          ra_o1;
    logic [AW-1:0]          wa;
    logic [SAMPLE_BITS-1:0] rd_e0;
    logic [SAMPLE_BITS-1:0] rd_e1;
    logic [SAMPLE_BITS-1:0] rd_o0;
    logic [SAMPLE_BITS-1:0] rd_o1;

    always_comb begin
        rd_en = adv && r3_vld && (r3_op == OP_INTERP);
        wr_en = adv && r3_vld && (r3_op == OP_WRITE);
        row_e = r3_y0[0] ? r3_y1 : r3_y0;
        row_o = r3_y0[0] ? r3_y0 : r3_y1;
        ra_e0 = {HR_W'(row_e >> 1), r3_x0};
        ra_e1 = {HR_W'(row_e >> 1), r3_x1};
        ra_o0 = {HR_W'(row_o >> 1), r3_x0};
        ra_o1 = {HR_W'(row_o >> 1), r3_x1};
        wa    = {HR_W'(r3_row >> 1), r3_col};
    end

    bu2d_bank #(
        .AW (AW),
        .DW (SAMPLE_BITS)
    ) u_bank_even (
        .i_clk    (i_clk),
        .i_we     (wr_en && !r3_row[0]),
        .i_waddr  (wa),
        .i_wdata  (r3_smp),
        .i_re     (rd_en),
        .i_raddr0 (ra_e0),
        .i_raddr1 (ra_e1),
        .o_rdata0 (rd_e0),
        .o_rdata1 (rd_e1)
    );

    bu2d_bank #(
        .AW (AW),
        .DW (SAMPLE_BITS)
    ) u_bank_odd (
        .i_clk    (i_clk),
        .i_we     (wr_en && r3_row[0]),
        .i_waddr  (wa),
        .i_wdata  (r3_smp),
        .i_re     (rd_en),
        .i_raddr0 (ra_o0),
        .i_raddr1 (ra_o1),
        .o_rdata0 (rd_o0),
        .o_rdata1 (rd_o1)
    );

    // Stage 4: bank data arrives; steering and the horizontal blend.
    logic                 r4_vld;
    logic [FRAC_BITS-1:0] r4_fy;
    logic [FRAC_BITS-1:0] r4_fx;
    logic                 r4_swap;
    logic                 r4_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (adv) begin
            r4_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_fy   <= r3_fy;
            r4_fx   <= r3_fx;
            r4_swap <= r3_y0[0];
            r4_ey   <= r3_ey;
        end
    end

    logic signed [SAMPLE_BITS-1:0] p00;
    logic signed [SAMPLE_BITS-1:0] p01;
    logic signed [SAMPLE_BITS-1:0] p10;
    logic signed [SAMPLE_BITS-1:0] p11;
    logic signed [W_W-1:0]         wx0;
    logic signed [W_W-1:0]         wx1;
    logic signed [TOP_W-1:0]       n5_top;
    logic signed [TOP_W-1:0]       n5_bot;

    always_comb begin
        p00    = r4_swap ? rd_o0 : rd_e0;
        p01    = r4_swap ? rd_o1 : rd_e1;
        p10    = r4_ey ? p00 : (r4_swap ? rd_e0 : rd_o0);
        p11    = r4_ey ? p01 : (r4_swap ? rd_e1 : rd_o1);
        wx1    = W_W'(r4_fx);
        wx0    = W_W'(ONE_Q16) - wx1;
        n5_top = wx0 * p00 + wx1 * p01;
        n5_bot = wx0 * p10 + wx1 * p11;
    end

    // Stage 5: vertical blend of the two row results.
    logic                    r5_vld;
    logic signed [TOP_W-1:0] r5_top;
    logic signed [TOP_W-1:0] r5_bot;
    logic [FRAC_BITS-1:0]    r5_fy;
    logic signed [W_W-1:0]   wy0;
    logic signed [W_W-1:0]   wy1;
    logic signed [ACC_W-1:0] n6_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_top <= n5_top;
            r5_bot <= n5_bot;
            r5_fy  <= r4_fy;
        end
    end

    always_comb begin
        wy1    = W_W'(r5_fy);
        wy0    = W_W'(ONE_Q16) - wy1;
        n6_acc = wy0 * r5_top + wy1 * r5_bot;
    end

    // Stage 6: round half up, drop the 32 fraction bits, saturate.
    logic                          r6_vld;
    logic signed [ACC_W-1:0]       r6_acc;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [V_W-1:0]         v;
    logic signed [V_W-1:0]         sat_hi;
    logic signed [V_W-1:0]         sat_lo;
    logic signed [SAMPLE_BITS-1:0] n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (adv) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_acc <= n6_acc;
        end
    end

    always_comb begin
        rnd    = r6_acc + {{(ACC_W-32){1'b0}}, 1'b1, 31'b0};
        v      = V_W'(rnd >>> 32);
        sat_hi = {{(V_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        sat_lo = ~sat_hi;
        if (v > sat_hi) begin
            n_out = sat_hi[SAMPLE_BITS-1:0];
        end else if (v < sat_lo) begin
            n_out = sat_lo[SAMPLE_BITS-1:0];
        end else begin
            n_out = v[SAMPLE_BITS-1:0];
        end
    end

    // Output register.
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_val <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.value = r_out_val;
endmodule

/* rtl/bu2d_bank.sv */
// ---------------------------------------------------------------------------
// bu2d_bank
// Pixel bank with one write port and two registered read ports.
// ---------------------------------------------------------------------------
module bu2d_bank
    import bu2d_pkg::*;
#(
    parameter int AW = 15,
    parameter int DW = DEF_SAMPLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [DW-1:0] o_rdata0,
    output logic [DW-1:0] o_rdata1
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd0;
    logic [DW-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;
endmodule

/* rtl/bu2d_checker.sv */
// ---------------------------------------------------------------------------
// bu2d_checker
// Port-level checks of the bilinear upsampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "bilinear_upsample_2d_assert.svh"

module bu2d_checker
    import bu2d_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_value
);
    // A stalled result stays offered and unchanged.
    `BU2D_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `BU2D_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value))

    // The pipeline only stalls on a waiting result.
    `BU2D_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `BU2D_ASSERT_IMP(a_ready_taken, i_clk, i_rst_n, i_out_valid && i_out_ready, i_in_ready)

    // Reset empties the result register.
    `BU2D_ASSERT_ALW(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind bilinear_upsample_2d bu2d_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bu2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value)
);

/* tb/sv/bu2d_checker.sv */
// ---------------------------------------------------------------------------
// bu2d_scoreboard
// Watches the channels of the bilinear upsampler and checks every result.
// ---------------------------------------------------------------------------
module bu2d_scoreboard
    import bu2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bu2d_in_if                    i_in,
    bu2d_out_if                   i_out,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [15:0] plane_mem [65536];
    logic [8:0]  height_r, width_r;
    logic [23:0] step_h_r, step_w_r;
    logic        corners_r;
    logic signed [15:0] pixel_q [$];

    function automatic longint clamp_size(input logic [8:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return longint'(s);
    endfunction

    function automatic void map_coord(input longint step, input longint dst,
                                      input longint size, output longint idx,
                                      output longint frac);
        longint src, t;
        if (corners_r) begin
            src = step * dst;
        end else begin
            t = step * (2 * dst + 1);
            src = (t >= 65536) ? ((t - 65536) >> 1) : 0;
        end
        if ((src >> FRAC_BITS) > size - 1) begin
            idx  = size - 1;
            frac = 0;
        end else begin
            idx  = src >> FRAC_BITS;
            frac = src & 64'hFFFF;
        end
    endfunction

    function automatic longint px(input longint r, input longint c);
        return longint'(plane_mem[{r[7:0], c[7:0]}]);
    endfunction

    function automatic logic signed [15:0] bilinear_pixel(input longint oy,
                                                          input longint ox);
        longint hs, ws, y0, y1, x0, x1, fy, fx, top, bot, acc, v;
        hs = clamp_size(height_r);
        ws = clamp_size(width_r);
        map_coord(longint'(step_h_r), oy, hs, y0, fy);
        map_coord(longint'(step_w_r), ox, ws, x0, fx);
        y1 = (y0 < hs - 1) ? y0 + 1 : y0;
        x1 = (x0 < ws - 1) ? x0 + 1 : x0;
        top = (65536 - fx) * px(y0, x0) + fx * px(y0, x1);
        bot = (65536 - fx) * px(y1, x0) + fx * px(y1, x1);
        acc = (65536 - fy) * top + fy * bot;
        // Arithmetic shift of a signed value is a floor division.
        v = (acc + (longint'(1) << 31)) >>> 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        logic signed [15:0] want;
        if (!i_rst_n) begin
            height_r     <= 9'd1;
            width_r      <= 9'd1;
            step_h_r     <= 24'd65536;
            step_w_r     <= 24'd65536;
            corners_r    <= 1'b0;
            pixel_q.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IN_HEIGHT:     height_r  <= i_cfg_data[8:0];
                    REG_IN_WIDTH:      width_r   <= i_cfg_data[8:0];
                    REG_SCALE_H:       step_h_r  <= i_cfg_data[23:0];
                    REG_SCALE_W:       step_w_r  <= i_cfg_data[23:0];
                    REG_ALIGN_CORNERS: corners_r <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.op == OP_WRITE) begin
                    plane_mem[{i_in.row, i_in.col}] <= i_in.sample;
                end else begin
                    pixel_q.push_back(bilinear_pixel(i_in.out_y, i_in.out_x));
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, i_out.value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (want !== i_out.value) begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, want, i_out.value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= pixel_q.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bilinear upsampler.
// ---------------------------------------------------------------------------
// Each random phase programs all five registers while the block is idle, fills
// the configured region of the plane so that no interpolate ever touches an
// unwritten sample, and then mixes interpolate and write transactions. The
// checker beside the block predicts every pixel and counts mismatches.
// ---------------------------------------------------------------------------
module tb;
    import bu2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL  = 1950;
    localparam int QUIET_FROM = 1800;
    localparam int STALL_MAX  = 3000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    sent_count;
    int                    results_seen;
    bit                    quiet;

    bu2d_in_if  in_ch ();
    bu2d_out_if out_ch ();

    bilinear_upsample_2d dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bu2d_scoreboard checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sends one transaction. Valid stays high across back-to-back transactions;
    // it is lowered only for a random gap. Ready is looked at on the falling
    // edge, where it is stable, so acceptance on the next rising edge is known.
    task automatic send(input logic op, input logic [7:0] row, input logic [7:0] col,
                        input logic [15:0] smp, input logic [11:0] oy,
                        input logic [11:0] ox);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.row    <= row;
        in_ch.col    <= col;
        in_ch.sample <= smp;
        in_ch.out_y  <= oy;
        in_ch.out_x  <= ox;
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        @(posedge i_clk);
        sent_count++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // Write transactions give no result, so allow the pipeline to drain.
        repeat (12) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [8:0] h, input logic [8:0] w,
                                input logic [23:0] sh, input logic [23:0] sw,
                                input logic ac);
        go_idle();
        cfg_we <= 1'b1; cfg_idx <= REG_IN_HEIGHT;     cfg_data <= 24'(h);  @(posedge i_clk);
        cfg_idx <= REG_IN_WIDTH;      cfg_data <= 24'(w);  @(posedge i_clk);
        cfg_idx <= REG_SCALE_H;       cfg_data <= sh;      @(posedge i_clk);
        cfg_idx <= REG_SCALE_W;       cfg_data <= sw;      @(posedge i_clk);
        cfg_idx <= REG_ALIGN_CORNERS; cfg_data <= 24'(ac); @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_scale();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'd65536;
            3:       return 24'($urandom_range(0, 65536));
            4:       return 24'($urandom);
            default: return 24'($urandom_range(4096, 200000));
        endcase
    endfunction

    // Writes every sample that the configured size can reach.
    task automatic fill_region(input int h, input int w);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send(OP_WRITE, 8'(r), 8'(c), rand_sample(), 12'($urandom), 12'($urandom));
    endtask

    // One phase of random traffic; writes land inside the filled region or
    // anywhere in the store, since either keeps every read well-defined.
    task automatic random_traffic(input int h, input int w, input int n);
        logic [11:0] oy, ox;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) begin
                // The sender holds back until every result has come.
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 1))
                    send(OP_WRITE, 8'($urandom_range(0, h - 1)), 8'($urandom_range(0, w - 1)),
                         rand_sample(), 12'($urandom), 12'($urandom));
                else
                    send(OP_WRITE, 8'($urandom), 8'($urandom), rand_sample(),
                         12'($urandom), 12'($urandom));
            end else begin
                oy = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
                ox = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
                send(OP_INTERP, 8'($urandom), 8'($urandom), 16'($urandom), oy, ox);
            end
        end
    endtask

    // Result side: random stall bursts, one long hold-off so the block backs
    // up into its input, and no stalls once the quiet tail begins.
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_seen > 150) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog: cycles in a row without any accepted transaction or result.
    initial begin
        int idle_run;
        idle_run = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) results_seen++;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_MAX) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int h, w;
        quiet = 1'b0;
        sent_count = 0;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_IN_HEIGHT;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_WRITE;
        in_ch.row <= '0;
        in_ch.col <= '0;
        in_ch.sample <= '0;
        in_ch.out_y <= '0;
        in_ch.out_x <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings are a single pixel plane.
        send(OP_WRITE, 8'd0, 8'd0, 16'h8000, 12'd0, 12'd0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd0, 12'd0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'hFFF, 12'hFFF);
        send(OP_WRITE, 8'hFF, 8'hFF, 16'h7FFF, 12'd0, 12'd0);
        // Aligned corners on a 2x2 plane at half step, extremes in the corners.
        program_regs(9'd2, 9'd2, 24'd32768, 24'd32768, 1'b1);
        send(OP_WRITE, 8'd0, 8'd0, 16'h7FFF, 12'd0, 12'd0);
        send(OP_WRITE, 8'd0, 8'd1, 16'h8000, 12'd0, 12'd0);
        send(OP_WRITE, 8'd1, 8'd0, 16'h8000, 12'd0, 12'd0);
        send(OP_WRITE, 8'd1, 8'd1, 16'h7FFF, 12'd0, 12'd0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd0, 12'd0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd1, 12'd1);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd2, 12'd3);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'hFFF, 12'd0);
        // Half-pixel centers with the clamp at zero, largest scale, zero size.
        program_regs(9'd0, 9'd2, 24'hFFFFFF, 24'd16384, 1'b0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd0, 12'd0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd5, 12'd3);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'hFFF, 12'hFFF);
        // Oversized height register acts as the largest plane.
        program_regs(9'd511, 9'd1, 24'd60000, 24'd0, 1'b1);
        fill_region(256, 1);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'd255, 12'd0);
        send(OP_INTERP, 8'd0, 8'd0, 16'd0, 12'hFFF, 12'd7);
        random_traffic(256, 1, 40);
        program_regs(9'd1, 9'd256, 24'd0, 24'd70000, 1'b0);
        fill_region(1, 256);
        random_traffic(1, 256, 40);

        while (sent_count < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0:       begin h = 0; w = $urandom_range(1, 6); end
                1:       begin h = $urandom_range(1, 6); w = 0; end
                default: begin h = $urandom_range(1, 8); w = $urandom_range(1, 8); end
            endcase
            program_regs(9'(h), 9'(w), rand_scale(), rand_scale(), 1'($urandom));
            if (h == 0) h = 1;
            if (w == 0) w = 1;
            fill_region(h, w);
            if (sent_count >= QUIET_FROM) quiet = 1'b1;
            random_traffic(h, w, 60);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
